FILE: rtl/core/nfcs_pkg.sv
// Shared constants, command/status types and cell helpers for the free cell search block.
package nfcs_pkg;

	localparam int GRID_W     = 64;
	localparam int GRID_H     = 64;
	localparam int CELLS      = GRID_W * GRID_H;
	localparam int XW         = $clog2(GRID_W);
	localparam int YW         = $clog2(GRID_H);
	localparam int ADDR_W     = XW + YW;
	localparam int MAX_RADIUS = 4096;
	localparam int COUNT_MAX  = 4096;
	localparam int CNT_W      = 13;
	localparam int TGT_W      = 9;
	localparam int BND_W      = 6;
	// origin within +-256 and bounds below 64 keep every ring radius under 1024
	localparam int RAD_W      = 10;
	localparam int CRD_W      = 12;
	localparam int OP_W       = 2;
	localparam int CFG_IDX_W  = 2;

	localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
	localparam logic [OP_W-1:0] OP_SET   = 2'd2;
	localparam logic [OP_W-1:0] OP_FIND  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_X = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_Y = 2'd3;

	// cell word: {present, occupied}
	localparam logic [1:0] CELL_ABSENT = 2'b00;
	localparam logic [1:0] CELL_FREE   = 2'b10;
	localparam logic [1:0] CELL_OCC    = 2'b11;

	typedef struct packed {
		logic accept;
		logic clr_init;
		logic clr_step;
		logic clr_report;
		logic update;
		logic walk_load;
		logic walk_run;
		logic srch_done;
	} nfcs_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic hit;
		logic walk_end;
	} nfcs_sts_t;

	typedef struct packed {
		logic [ADDR_W-1:0] rd_addr;
		logic              valid;
		logic              ok;
		logic              last;
		logic [XW-1:0]     x;
		logic [YW-1:0]     y;
	} nfcs_cand_t;

	function automatic logic in_grid(input logic signed [CRD_W-1:0] x,
			input logic signed [CRD_W-1:0] y);
		return (x >= 0) && (x < GRID_W) && (y >= 0) && (y < GRID_H);
	endfunction

	// row-major index; grid sides are powers of two so this is a concatenation
	function automatic logic [ADDR_W-1:0] cell_addr(input logic signed [CRD_W-1:0] x,
			input logic signed [CRD_W-1:0] y);
		return {y[YW-1:0], x[XW-1:0]};
	endfunction

endpackage

FILE: rtl/core/nfcs_ctrl.sv
// Controller state machine: sequences clear sweeps, cell updates and ring searches.
module nfcs_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [nfcs_pkg::OP_W-1:0]     operation,
	input  nfcs_pkg::nfcs_sts_t           sts,
	output logic                          busy,
	output nfcs_pkg::nfcs_cmd_t           cmd
);
	import nfcs_pkg::*;

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_READ   = 3'd2;
	localparam logic [2:0] S_UPDATE = 3'd3;
	localparam logic [2:0] S_LIMIT  = 3'd4;
	localparam logic [2:0] S_SEARCH = 3'd5;

	logic [2:0] state_q, state_d;
	logic       report_q, report_d;

	always_comb begin
		state_d  = state_q;
		report_d = report_q;
		cmd      = '0;
		busy     = 1'b1;
		case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.accept = 1'b1;
					case (operation)
						OP_CLEAR: begin
							cmd.clr_init = 1'b1;
							report_d     = 1'b1;
							state_d      = S_CLEAR;
						end
						OP_ADD, OP_SET: state_d = S_READ;
						OP_FIND: state_d = S_LIMIT;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					// the pass after reset finishes silently
					cmd.clr_report = report_q;
					report_d       = 1'b0;
					state_d        = S_IDLE;
				end
			end
			S_READ: state_d = S_UPDATE;
			S_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = S_IDLE;
			end
			S_LIMIT: begin
				cmd.walk_load = 1'b1;
				state_d       = S_SEARCH;
			end
			S_SEARCH: begin
				cmd.walk_run = 1'b1;
				if (sts.hit || sts.walk_end) begin
					cmd.srch_done = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			report_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			report_q <= report_d;
		end
	end

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but controller not busy");

	a_one_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.clr_report, cmd.update, cmd.srch_done}) <= 1)
		else $error("two results finished in one cycle");

	a_search_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_load |=> cmd.walk_run)
		else $error("walker loaded but search not running");

endmodule

FILE: rtl/core/nfcs_ring_walk.sv
// Ring walker: origin, then square rings of growing radius, one candidate per cycle.
module nfcs_ring_walk (
	input  logic                                clk,
	input  logic                                arst_n,
	input  nfcs_pkg::nfcs_cmd_t                 cmd,
	input  logic signed [nfcs_pkg::TGT_W-1:0]   tgt_x,
	input  logic signed [nfcs_pkg::TGT_W-1:0]   tgt_y,
	input  logic [nfcs_pkg::BND_W-1:0]          bnd_min_x,
	input  logic [nfcs_pkg::BND_W-1:0]          bnd_min_y,
	input  logic [nfcs_pkg::BND_W-1:0]          bnd_max_x,
	input  logic [nfcs_pkg::BND_W-1:0]          bnd_max_y,
	output nfcs_pkg::nfcs_cand_t                cand
);
	import nfcs_pkg::*;

	localparam int LIM_W = $clog2(MAX_RADIUS + 1);
	localparam logic signed [CRD_W-1:0] CRD_ONE = CRD_W'(1);

	localparam logic [1:0] PH_ORIGIN = 2'd0;
	localparam logic [1:0] PH_TOPBOT = 2'd1;
	localparam logic [1:0] PH_SIDES  = 2'd2;

	logic [1:0]              phase_q;
	logic                    side_q;
	logic                    active_q;
	logic [RAD_W-1:0]        r_q;
	logic [RAD_W-1:0]        limit_q;
	logic signed [CRD_W-1:0] d_q;

	logic signed [CRD_W-1:0] ox, oy, r_s, cx, cy;
	logic [RAD_W-1:0]        dist_x0, dist_x1, dist_y0, dist_y1, dist_x, dist_y, raw_lim;
	logic [RAD_W-1:0]        lim_d;
	logic                    is_last;

	logic                    valid_s1, ok_s1, last_s1;
	logic [XW-1:0]           x_s1;
	logic [YW-1:0]           y_s1;

	function automatic logic [RAD_W-1:0] absdiff(input logic signed [CRD_W-1:0] a,
			input logic [BND_W-1:0] b);
		logic signed [CRD_W-1:0] diff;
		diff = a - $signed(CRD_W'(b));
		return (diff < 0) ? RAD_W'(-diff) : RAD_W'(diff);
	endfunction

	assign ox  = CRD_W'(tgt_x);
	assign oy  = CRD_W'(tgt_y);
	assign r_s = $signed(CRD_W'(r_q));

	// search limit: farthest bound from the origin, capped
	always_comb begin
		dist_x0 = absdiff(ox, bnd_min_x);
		dist_x1 = absdiff(ox, bnd_max_x);
		dist_y0 = absdiff(oy, bnd_min_y);
		dist_y1 = absdiff(oy, bnd_max_y);
		dist_x  = (dist_x0 > dist_x1) ? dist_x0 : dist_x1;
		dist_y  = (dist_y0 > dist_y1) ? dist_y0 : dist_y1;
		raw_lim = (dist_x > dist_y) ? dist_x : dist_y;
		lim_d   = (LIM_W'(raw_lim) > LIM_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : raw_lim;
	end

	always_comb begin
		case (phase_q)
			PH_TOPBOT: begin
				cx = ox + d_q;
				cy = side_q ? (oy + r_s) : (oy - r_s);
			end
			PH_SIDES: begin
				cx = side_q ? (ox + r_s) : (ox - r_s);
				cy = oy + d_q;
			end
			default: begin
				cx = ox;
				cy = oy;
			end
		endcase
		is_last = ((phase_q == PH_ORIGIN) && (limit_q == '0)) ||
			((phase_q == PH_SIDES) && side_q && (d_q == r_s - CRD_ONE) && (r_q == limit_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_ORIGIN;
			side_q   <= 1'b0;
			active_q <= 1'b0;
			valid_s1 <= 1'b0;
		end else if (cmd.walk_load) begin
			phase_q  <= PH_ORIGIN;
			side_q   <= 1'b0;
			active_q <= 1'b1;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.walk_run && active_q;
			if (cmd.walk_run && active_q) begin
				if (is_last)
					active_q <= 1'b0;
				case (phase_q)
					PH_ORIGIN: begin
						phase_q <= PH_TOPBOT;
						side_q  <= 1'b0;
					end
					PH_TOPBOT: begin
						side_q <= !side_q;
						if (side_q && (d_q == r_s))
							phase_q <= PH_SIDES;
					end
					PH_SIDES: begin
						side_q <= !side_q;
						if (side_q && (d_q == r_s - CRD_ONE))
							phase_q <= PH_TOPBOT;
					end
					default: phase_q <= PH_ORIGIN;
				endcase
			end
		end
	end

	// radius and offset; the top/bottom pass covers -r..r, the sides -r+1..r-1
	always_ff @(posedge clk) begin
		if (cmd.walk_load) begin
			limit_q <= lim_d;
			r_q     <= '0;
			d_q     <= '0;
		end else if (cmd.walk_run && active_q) begin
			case (phase_q)
				PH_ORIGIN: begin
					r_q <= RAD_W'(1);
					d_q <= -CRD_W'(1);
				end
				PH_TOPBOT: begin
					if (side_q)
						d_q <= (d_q == r_s) ? (CRD_ONE - r_s) : (d_q + CRD_ONE);
				end
				PH_SIDES: begin
					if (side_q) begin
						if (d_q == r_s - CRD_ONE) begin
							r_q <= r_q + RAD_W'(1);
							d_q <= -(r_s + CRD_ONE);
						end else begin
							d_q <= d_q + CRD_ONE;
						end
					end
				end
				default: d_q <= d_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		x_s1    <= cx[XW-1:0];
		y_s1    <= cy[YW-1:0];
		ok_s1   <= in_grid(cx, cy);
		last_s1 <= is_last;
	end

	assign cand.rd_addr = cell_addr(cx, cy);
	assign cand.valid   = valid_s1;
	assign cand.ok      = ok_s1;
	assign cand.last    = last_s1;
	assign cand.x       = x_s1;
	assign cand.y       = y_s1;

	a_load_clears_s1: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_load |=> !valid_s1)
		else $error("stale candidate after walker load");

	a_stop_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.walk_run && active_q && is_last && !cmd.walk_load) |=> !active_q)
		else $error("walker kept running past its last position");

	a_radius_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q && !cmd.walk_load) |-> (r_q <= limit_q))
		else $error("ring radius beyond search limit");

endmodule

FILE: rtl/core/nfcs_dp.sv
// Datapath: cell map memory, free counter, bound registers, request latch and result register.
module nfcs_dp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  nfcs_pkg::nfcs_cmd_t                    cmd,
	input  logic [nfcs_pkg::OP_W-1:0]              operation,
	input  logic signed [nfcs_pkg::TGT_W-1:0]      target_x,
	input  logic signed [nfcs_pkg::TGT_W-1:0]      target_y,
	input  logic                                   occupied_flag,
	input  logic                                   cfg_valid,
	input  logic [nfcs_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [nfcs_pkg::BND_W-1:0]             cfg_data,
	input  nfcs_pkg::nfcs_cand_t                   cand,
	output nfcs_pkg::nfcs_sts_t                    sts,
	output logic signed [nfcs_pkg::TGT_W-1:0]      tgt_x,
	output logic signed [nfcs_pkg::TGT_W-1:0]      tgt_y,
	output logic [nfcs_pkg::BND_W-1:0]             bnd_min_x,
	output logic [nfcs_pkg::BND_W-1:0]             bnd_min_y,
	output logic [nfcs_pkg::BND_W-1:0]             bnd_max_x,
	output logic [nfcs_pkg::BND_W-1:0]             bnd_max_y,
	output logic                                   result_valid,
	output logic                                   found,
	output logic [nfcs_pkg::XW-1:0]                cell_x,
	output logic [nfcs_pkg::YW-1:0]                cell_y,
	output logic [nfcs_pkg::CNT_W-1:0]             free_count
);
	import nfcs_pkg::*;

	logic [1:0]              mem [CELLS];
	logic [1:0]              rd_q;
	logic [ADDR_W-1:0]       clr_cnt_q;
	logic [CNT_W-1:0]        free_q;

	logic [OP_W-1:0]         op_q;
	logic signed [TGT_W-1:0] tx_q, ty_q;
	logic                    flag_q;
	logic [BND_W-1:0]        min_x_q, min_y_q, max_x_q, max_y_q;

	logic                    res_valid_q, res_found_q;
	logic [XW-1:0]           res_x_q;
	logic [YW-1:0]           res_y_q;

	logic signed [CRD_W-1:0] tgt_cx, tgt_cy;
	logic                    tgt_ing;
	logic [ADDR_W-1:0]       tgt_addr;
	logic                    pres, occ;
	logic                    upd_we, upd_hit, cnt_up, cnt_dn;
	logic [1:0]              upd_wd;
	logic                    mem_we;
	logic [ADDR_W-1:0]       mem_wa, mem_ra;
	logic [1:0]              mem_wd;
	logic                    hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_x_q <= '0;
			min_y_q <= '0;
			max_x_q <= '1;
			max_y_q <= '1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MIN_X: min_x_q <= cfg_data;
				REG_MIN_Y: min_y_q <= cfg_data;
				REG_MAX_X: max_x_q <= cfg_data;
				REG_MAX_Y: max_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= operation;
			tx_q   <= target_x;
			ty_q   <= target_y;
			flag_q <= occupied_flag;
		end
	end

	assign tgt_cx   = CRD_W'(tx_q);
	assign tgt_cy   = CRD_W'(ty_q);
	assign tgt_ing  = in_grid(tgt_cx, tgt_cy);
	assign tgt_addr = cell_addr(tgt_cx, tgt_cy);

	// word from memory is {present, occupied}
	assign pres = rd_q[1];
	assign occ  = rd_q[0];

	always_comb begin
		upd_we  = 1'b0;
		upd_wd  = CELL_FREE;
		upd_hit = 1'b0;
		cnt_up  = 1'b0;
		cnt_dn  = 1'b0;
		case (op_q)
			OP_ADD: begin
				if (tgt_ing) begin
					upd_we  = 1'b1;
					upd_hit = 1'b1;
					cnt_up  = !pres || occ;
				end
			end
			OP_SET: begin
				if (tgt_ing && pres) begin
					upd_hit = 1'b1;
					if (occ != flag_q) begin
						upd_we = 1'b1;
						upd_wd = flag_q ? CELL_OCC : CELL_FREE;
						cnt_up = !flag_q;
						cnt_dn = flag_q;
					end
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		mem_we = cmd.clr_step || (cmd.update && upd_we);
		mem_wa = cmd.clr_step ? clr_cnt_q : tgt_addr;
		mem_wd = cmd.clr_step ? CELL_ABSENT : upd_wd;
		mem_ra = cmd.walk_run ? cand.rd_addr : tgt_addr;
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		rd_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_cnt_q <= '0;
		else if (cmd.clr_init)
			clr_cnt_q <= '0;
		else if (cmd.clr_step)
			clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= '0;
		end else if (cmd.clr_init) begin
			free_q <= '0;
		end else if (cmd.update) begin
			if (cnt_up && (free_q < CNT_W'(COUNT_MAX)))
				free_q <= free_q + CNT_W'(1);
			else if (cnt_dn && (free_q != '0))
				free_q <= free_q - CNT_W'(1);
		end
	end

	assign hit = cand.valid && cand.ok && (rd_q == CELL_FREE);

	assign sts.clr_last = (clr_cnt_q == ADDR_W'(CELLS - 1));
	assign sts.hit      = hit;
	assign sts.walk_end = cand.valid && cand.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else
			res_valid_q <= cmd.clr_report || cmd.update || cmd.srch_done;
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_report) begin
			res_found_q <= 1'b0;
			res_x_q     <= '0;
			res_y_q     <= '0;
		end else if (cmd.update) begin
			res_found_q <= upd_hit;
			res_x_q     <= upd_hit ? tx_q[XW-1:0] : '0;
			res_y_q     <= upd_hit ? ty_q[YW-1:0] : '0;
		end else if (cmd.srch_done) begin
			res_found_q <= hit;
			res_x_q     <= hit ? cand.x : '0;
			res_y_q     <= hit ? cand.y : '0;
		end
	end

	assign tgt_x        = tx_q;
	assign tgt_y        = ty_q;
	assign bnd_min_x    = min_x_q;
	assign bnd_min_y    = min_y_q;
	assign bnd_max_x    = max_x_q;
	assign bnd_max_y    = max_y_q;
	assign result_valid = res_valid_q;
	assign found        = res_found_q;
	assign cell_x       = res_x_q;
	assign cell_y       = res_y_q;
	assign free_count   = free_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= CNT_W'(COUNT_MAX))
		else $error("free count above grid size");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_found_q) |-> (res_x_q == '0 && res_y_q == '0))
		else $error("miss result with nonzero coordinates");

	a_no_write_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_run |-> !mem_we)
		else $error("cell map written during search");

	a_result_gap: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |=> !res_valid_q)
		else $error("results on back-to-back cycles");

endmodule

FILE: rtl/core/nearest_free_cell_search.sv
// Top level of the nearest free cell search block.
// Add cell and set occupancy: read and update states, then a registered result strobe.
// Find nearest: positions walked are the origin, then 8r per ring up to the limit;
//   one cell map memory read per position, ending at the first free cell in the grid.
// Clear map: one memory entry cleared per cycle. Results cannot be stalled.
// Reset: a clearing pass over every map entry runs with busy high; configuration writes are taken meanwhile.
module nearest_free_cell_search (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [nfcs_pkg::OP_W-1:0]             operation,
	input  logic signed [nfcs_pkg::TGT_W-1:0]     target_x,
	input  logic signed [nfcs_pkg::TGT_W-1:0]     target_y,
	input  logic                                  occupied_flag,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [nfcs_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [nfcs_pkg::BND_W-1:0]            cfg_data,
	output logic                                  result_valid,
	output logic                                  found,
	output logic [nfcs_pkg::XW-1:0]               cell_x,
	output logic [nfcs_pkg::YW-1:0]               cell_y,
	output logic [nfcs_pkg::CNT_W-1:0]            free_count
);
	import nfcs_pkg::*;

	nfcs_cmd_t               cmd;
	nfcs_sts_t               sts;
	nfcs_cand_t              cand;
	logic signed [TGT_W-1:0] tgt_x, tgt_y;
	logic [BND_W-1:0]        bnd_min_x, bnd_min_y, bnd_max_x, bnd_max_y;

	// bounds only feed the search limit, so writes are always taken
	assign cfg_ready = 1'b1;

	nfcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.sts       (sts),
		.busy      (busy),
		.cmd       (cmd)
	);

	nfcs_ring_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.tgt_x     (tgt_x),
		.tgt_y     (tgt_y),
		.bnd_min_x (bnd_min_x),
		.bnd_min_y (bnd_min_y),
		.bnd_max_x (bnd_max_x),
		.bnd_max_y (bnd_max_y),
		.cand      (cand)
	);

	nfcs_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.operation     (operation),
		.target_x      (target_x),
		.target_y      (target_y),
		.occupied_flag (occupied_flag),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cand          (cand),
		.sts           (sts),
		.tgt_x         (tgt_x),
		.tgt_y         (tgt_y),
		.bnd_min_x     (bnd_min_x),
		.bnd_min_y     (bnd_min_y),
		.bnd_max_x     (bnd_max_x),
		.bnd_max_y     (bnd_max_y),
		.result_valid  (result_valid),
		.found         (found),
		.cell_x        (cell_x),
		.cell_y        (cell_y),
		.free_count    (free_count)
	);

	a_no_result_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !result_valid)
		else $error("result strobe right after a request was accepted");

	a_result_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("result shown while still busy");

	a_busy_during_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_step |-> busy)
		else $error("clear sweep while idle");

endmodule
